// ===== sv/lsb_stego_embed_extract_top_macros.svh =====
// ----------------------------------------------------------------------------
// LSB stego engine assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EMBED_EXTRACT_TOP_MACROS_SVH
`define LSB_STEGO_EMBED_EXTRACT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// General property check
`define LSBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication check
`define LSBSE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `LSBSE_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define LSBSE_ASSERT(lbl, prop, msg)
`define LSBSE_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// LSB stego engine package
// Shared types, constants and helper functions of the embed/extract engine.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  localparam int IMAGE_BYTES_DEFAULT = 4096;
  localparam int ADDR_W  = 12;
  localparam int LEN_W   = 13;
  localparam int CUR_W   = 14;
  localparam int DEPTH_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_READ    = 3'd1,
    OP_START   = 3'd2,
    OP_EMBED   = 3'd3,
    OP_EXTRACT = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH  = 2'd0,
    CFG_ALPHA  = 2'd1,
    CFG_LENGTH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_HDR,
    S_XFER_RD,
    S_XFER_MOD
  } state_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [7:0]        value;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         result_byte;
    logic               complete;
    logic [DEPTH_W-1:0] active_depth;
  } res_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [2:0]         offset;
    logic [3:0]         remaining;
    logic [7:0]         pixel;
    logic [7:0]         data;
    logic               writing;
  } xfer_in_t;

  typedef struct packed {
    logic [7:0] new_cell;
    logic [7:0] bits;
    logic [2:0] offset_next;
    logic [3:0] remaining_next;
    logic       wrap;
  } xfer_out_t;

  // Depth encoded by a header byte of k low ones; zero for any other pattern.
  function automatic logic [DEPTH_W-1:0] header_depth(input logic [7:0] hdr);
    logic [DEPTH_W-1:0] d;
    logic run;
    logic bad;
    d   = '0;
    run = 1'b1;
    bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (hdr[i]) begin
        if (run) d = d + 1'b1;
        else bad = 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return bad ? '0 : d;
  endfunction

  function automatic logic [7:0] header_byte(input logic [DEPTH_W-1:0] depth);
    return 8'hFF >> (4'd8 - depth);
  endfunction

endpackage

// ===== sv/lsbse_store.sv =====
// ----------------------------------------------------------------------------
// LSB stego engine cover image store
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module lsbse_store #(
  parameter int IMAGE_BYTES = lsbse_pkg::IMAGE_BYTES_DEFAULT,
  parameter int AW          = $clog2(IMAGE_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import lsbse_pkg::*;

  logic [7:0] mem [IMAGE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lsbse_field_unit.sv =====
// ----------------------------------------------------------------------------
// LSB stego engine bit-field unit
// Moves one bit field between a data byte and one image byte per use.
// ----------------------------------------------------------------------------
module lsbse_field_unit (
  input  lsbse_pkg::xfer_in_t  xin,
  output lsbse_pkg::xfer_out_t xout
);
  import lsbse_pkg::*;

  logic [3:0] room;
  logic [3:0] take;
  logic [3:0] shift;
  logic [3:0] lowpos;
  logic [7:0] mask;
  logic [7:0] field;
  logic [3:0] sum;

  always_comb begin
    room   = xin.depth - {1'b0, xin.offset};
    take   = (xin.remaining < room) ? xin.remaining : room;
    shift  = room - take;
    lowpos = xin.remaining - take;
    mask   = 8'((9'd1 << take) - 9'd1);
    field  = (xin.data >> lowpos) & mask;
    sum    = {1'b0, xin.offset} + take;

    xout.new_cell       = (xin.pixel & ~(mask << shift)) | (field << shift);
    xout.bits           = ((xin.pixel >> shift) & mask) << lowpos;
    xout.wrap           = (sum >= xin.depth);
    xout.offset_next    = xout.wrap ? 3'd0 : sum[2:0];
    xout.remaining_next = xin.remaining - take;
  end

endmodule

// ===== sv/lsbse_seq.sv =====
// ----------------------------------------------------------------------------
// LSB stego engine sequencer
// Runs each command over the image store, reusing the bit-field unit once
// per image byte touched, and registers the result transaction.
// ----------------------------------------------------------------------------
module lsbse_seq #(
  parameter int IMAGE_BYTES = lsbse_pkg::IMAGE_BYTES_DEFAULT,
  parameter int AW          = $clog2(IMAGE_BYTES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lsbse_pkg::cmd_t               command,
  output logic                          busy,
  input  logic [lsbse_pkg::DEPTH_W-1:0] depth_setting,
  input  logic                          alpha_present,
  input  logic [lsbse_pkg::LEN_W-1:0]   image_length,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [7:0]                    mem_rdata,
  output logic                          done,
  output lsbse_pkg::res_t               result
);
  import lsbse_pkg::*;

  state_t state, state_next;
  cmd_t   cmd;

  logic [CUR_W-1:0]   cursor, cursor_next;
  logic [2:0]         bit_offset, bit_offset_next;
  logic [DEPTH_W-1:0] depth_in_use, depth_in_use_next;
  logic [LEN_W-1:0]   capacity, capacity_next;
  logic [3:0]         remaining, remaining_next;
  logic [7:0]         got, got_next;
  logic               finish;
  res_t               fin_result;

  logic [LEN_W-1:0]   len;
  logic [DEPTH_W-1:0] depth_eff;
  logic [DEPTH_W-1:0] hdr_depth;
  logic               addr_ok;
  logic               xfer_end;
  logic [CUR_W-1:0]   cursor_inc;
  logic [CUR_W-1:0]   cursor_adv;
  xfer_in_t           xin;
  xfer_out_t          xout;

  lsbse_field_unit u_field (
    .xin  (xin),
    .xout (xout)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    len        = (32'(image_length) > IMAGE_BYTES) ? LEN_W'(IMAGE_BYTES) : image_length;
    depth_eff  = (depth_setting > 4'd8) ? 4'd8 : depth_setting;
    hdr_depth  = header_depth(mem_rdata);
    addr_ok    = (32'(cmd.address) < IMAGE_BYTES);
    xfer_end   = (remaining == 4'd0) || (cursor >= {1'b0, capacity});
    // skip the alpha byte of each group of four
    cursor_inc = cursor + 1'b1;
    cursor_adv = (alpha_present && (cursor_inc[1:0] == 2'b11)) ? cursor_inc + 1'b1
                                                              : cursor_inc;
    xin.depth     = depth_in_use;
    xin.offset    = bit_offset;
    xin.remaining = remaining;
    xin.pixel     = mem_rdata;
    xin.data      = cmd.value;
    xin.writing   = (cmd.opcode == OP_EMBED);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cmd.opcode)
          OP_READ: state_next = S_READ;
          OP_START: begin
            if (depth_setting == '0 && len != '0) state_next = S_HDR;
            else state_next = S_IDLE;
          end
          OP_EMBED, OP_EXTRACT: begin
            if (depth_in_use != '0) state_next = S_XFER_RD;
            else state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ:     state_next = S_IDLE;
      S_HDR:      state_next = S_IDLE;
      S_XFER_RD:  state_next = xfer_end ? S_IDLE : S_XFER_MOD;
      S_XFER_MOD: state_next = S_XFER_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    mem_we            = 1'b0;
    mem_waddr         = AW'(cmd.address);
    mem_wdata         = cmd.value;
    mem_raddr         = '0;
    finish            = 1'b0;
    fin_result        = '0;
    cursor_next       = cursor;
    bit_offset_next   = bit_offset;
    depth_in_use_next = depth_in_use;
    capacity_next     = capacity;
    remaining_next    = remaining;
    got_next          = got;
    case (state)
      S_EXEC: begin
        case (cmd.opcode)
          OP_LOAD: begin
            mem_we = addr_ok;
            finish = 1'b1;
          end
          OP_READ: begin
            mem_raddr = AW'(cmd.address);
          end
          OP_START: begin
            cursor_next     = CUR_W'(1);
            bit_offset_next = 3'd0;
            if (depth_setting == '0) begin
              // header is read back unless length is zero
              if (len == '0) begin
                depth_in_use_next = '0;
                capacity_next     = '0;
                finish            = 1'b1;
              end
            end else begin
              depth_in_use_next = depth_eff;
              capacity_next     = len;
              mem_we            = (len != '0);
              mem_waddr         = '0;
              mem_wdata         = header_byte(depth_eff);
              finish            = 1'b1;
              fin_result.complete = (len != '0);
            end
          end
          OP_EMBED, OP_EXTRACT: begin
            remaining_next = 4'd8;
            got_next       = '0;
            if (depth_in_use == '0) finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end
      S_READ: begin
        finish                 = 1'b1;
        fin_result.result_byte = addr_ok ? mem_rdata : 8'd0;
      end
      S_HDR: begin
        finish            = 1'b1;
        depth_in_use_next = hdr_depth;
        capacity_next     = (hdr_depth != '0) ? len : '0;
        fin_result.complete = (hdr_depth != '0);
      end
      S_XFER_RD: begin
        mem_raddr = AW'(cursor);
        if (xfer_end) begin
          finish              = 1'b1;
          fin_result.complete = (remaining == 4'd0);
          if (cmd.opcode == OP_EXTRACT) fin_result.result_byte = got;
        end
      end
      S_XFER_MOD: begin
        mem_we          = xin.writing;
        mem_waddr       = AW'(cursor);
        mem_wdata       = xout.new_cell;
        got_next        = got | xout.bits;
        remaining_next  = xout.remaining_next;
        bit_offset_next = xout.offset_next;
        if (xout.wrap) cursor_next = cursor_adv;
      end
      default: begin
      end
    endcase
    fin_result.active_depth = depth_in_use_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor       <= '0;
      bit_offset   <= '0;
      depth_in_use <= '0;
      capacity     <= '0;
      remaining    <= '0;
      got          <= '0;
      done         <= 1'b0;
      result       <= '0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      bit_offset   <= bit_offset_next;
      depth_in_use <= depth_in_use_next;
      capacity     <= capacity_next;
      remaining    <= remaining_next;
      got          <= got_next;
      done         <= finish;
      if (finish) result <= fin_result;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) cmd <= command;
  end

endmodule

// ===== sv/lsb_stego_embed_extract_top.sv =====
// ----------------------------------------------------------------------------
// LSB stego embed/extract engine
// Hides data bytes in the low bits of a private cover image store and reads
// them back, with header-based depth setup and alpha byte skipping.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+-------------------------
//  command   | start, busy, command                      | start && !busy
//  result    | done, result                              | done, one cycle
//  config    | write_enable, write_index, write_data     | write_enable
//
//  Embed and extract work per image byte touched:
//  each image byte is a read-modify-write through the store's single read
//  port with registered data, handled by one shared bit-field unit.
//  busy is high from the cycle after start until done; results cannot stall.
//  rst is synchronous; the store holds undefined data until loaded.
// ----------------------------------------------------------------------------
`include "lsb_stego_embed_extract_top_macros.svh"

module lsb_stego_embed_extract_top #(
  parameter int IMAGE_BYTES = lsbse_pkg::IMAGE_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  lsbse_pkg::cmd_t                  command,
  output logic                             busy,
  input  logic                             write_enable,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [lsbse_pkg::CFG_DATA_W-1:0] write_data,
  output logic                             done,
  output lsbse_pkg::res_t                  result
);
  import lsbse_pkg::*;

  localparam int AW = $clog2(IMAGE_BYTES);

  logic [DEPTH_W-1:0] depth_setting;
  logic               alpha_present;
  logic [LEN_W-1:0]   image_length;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_setting <= 4'd1;
      alpha_present <= 1'b0;
      image_length  <= '0;
    end else if (write_enable) begin
      case (write_index)
        CFG_DEPTH:  depth_setting <= write_data[DEPTH_W-1:0];
        CFG_ALPHA:  alpha_present <= write_data[0];
        CFG_LENGTH: image_length  <= write_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lsbse_store #(
    .IMAGE_BYTES (IMAGE_BYTES),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lsbse_seq #(
    .IMAGE_BYTES (IMAGE_BYTES),
    .AW          (AW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .busy          (busy),
    .depth_setting (depth_setting),
    .alpha_present (alpha_present),
    .image_length  (image_length),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .done          (done),
    .result        (result)
  );

  `LSBSE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
  `LSBSE_ASSERT_IMPLY(a_done_after_busy, done, $past(busy), "result without a command in flight")
  `LSBSE_ASSERT(a_done_single, done |=> !done, "two result transactions back to back")
  `LSBSE_ASSERT_IMPLY(a_depth_range, done, result.active_depth <= 4'd8, "active depth above 8")

endmodule

// ===== tb/tb_lsb_stego_embed_extract_top.sv =====
// ----------------------------------------------------------------------------
// LSB stego embed/extract engine testbench
// Drives load, read, start, embed, extract and unknown commands through the
// start/busy handshake. A behavioral predictor tracks the cover image, the
// cursor and the depth, and each strobed result is compared with the oldest
// predicted one. Phases change the depth, alpha and length registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lsb_stego_embed_extract_top;
  import lsbse_pkg::*;

  localparam int STORE_BYTES = IMAGE_BYTES_DEFAULT;
  localparam int FILL_BYTES = 192;
  localparam int XFER_SPAN = 11;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 880;
  localparam int CALM_ITEMS = 740;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] OP_UNKNOWN_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t command = '0;
  logic busy;
  logic write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = '0;
  logic [CFG_DATA_W-1:0] write_data = '0;
  logic done;
  res_t result;

  // Predictor state
  logic [7:0] cover_mem [STORE_BYTES];
  int unsigned cur_pos = 0;
  int unsigned bit_pos = 0;
  int unsigned cur_depth = 0;
  int unsigned cur_cap = 0;
  int unsigned reg_depth = 1;
  int unsigned reg_alpha = 0;
  int unsigned reg_length = 0;

  cmd_t pending_cmds [$];
  res_t expected_results [$];
  int queued_total = 0;
  // upper bound on the image bytes the transfers since the last start can touch
  int reach = 0;
  int err_count = 0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_cycles = 0;

  lsb_stego_embed_extract_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .busy         (busy),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .done         (done),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Compute the result of one command and update the predicted image state.
  function automatic res_t stego_predict(input cmd_t c);
    res_t r;
    int unsigned len, hdr, d;
    int unsigned remaining, room, take, shift, mask, pix, got;
    r = '0;
    case (c.opcode)
      OP_LOAD: cover_mem[c.address] = c.value;
      OP_READ: r.result_byte = cover_mem[c.address];
      OP_START: begin
        len = (reg_length > STORE_BYTES) ? STORE_BYTES : reg_length;
        cur_pos = 1;
        bit_pos = 0;
        if (reg_depth == 0) begin
          hdr = (len != 0) ? cover_mem[0] : 0;
          d = 0;
          while (hdr[0]) begin
            d++;
            hdr = hdr >> 1;
          end
          if (hdr != 0 || d == 0) begin
            cur_depth = 0;
            cur_cap = 0;
          end else begin
            cur_depth = d;
            cur_cap = len;
          end
        end else begin
          cur_depth = (reg_depth > 8) ? 8 : reg_depth;
          cur_cap = len;
          if (len != 0) begin
            hdr = 32'hFF >> (8 - cur_depth);
            cover_mem[0] = hdr[7:0];
          end
        end
        r.complete = (cur_cap != 0);
      end
      OP_EMBED, OP_EXTRACT: begin
        if (cur_depth >= 1 && cur_depth <= 8) begin
          remaining = 8;
          got = 0;
          while (remaining != 0 && cur_pos < cur_cap && cur_pos < STORE_BYTES) begin
            room = cur_depth - bit_pos;
            take = (remaining < room) ? remaining : room;
            shift = cur_depth - bit_pos - take;
            mask = (1 << take) - 1;
            pix = cover_mem[cur_pos];
            if (c.opcode == OP_EMBED) begin
              pix = (pix & ~(mask << shift)) |
                    (((c.value >> (remaining - take)) & mask) << shift);
              cover_mem[cur_pos] = pix[7:0];
            end else begin
              got = got | (((pix >> shift) & mask) << (remaining - take));
            end
            bit_pos += take;
            remaining -= take;
            if (bit_pos >= cur_depth) begin
              // advance past the filled byte, skip alpha
              bit_pos = 0;
              cur_pos++;
              if (reg_alpha != 0 && (cur_pos % 4) == 3) cur_pos++;
            end
          end
          r.complete = (remaining == 0);
          if (c.opcode == OP_EXTRACT) r.result_byte = got[7:0];
        end
      end
      default: ;
    endcase
    r.active_depth = cur_depth[3:0];
    return r;
  endfunction

  function automatic void queue_cmd(input int unsigned op, input int unsigned addr,
                                    input int unsigned val);
    cmd_t c;
    c.opcode = 3'(op);
    c.address = ADDR_W'(addr);
    c.value = 8'(val);
    pending_cmds.push_back(c);
    queued_total++;
    if (c.opcode == OP_START) reach = 1;
    else if (c.opcode == OP_EMBED || c.opcode == OP_EXTRACT) reach += XFER_SPAN;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    case (idx)
      CFG_DEPTH: reg_depth = val[3:0];
      CFG_ALPHA: reg_alpha = val[0];
      default: reg_length = val;
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] d, input logic a, input logic [12:0] l);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(CFG_DEPTH, CFG_DATA_W'(d));
    write_reg(CFG_ALPHA, CFG_DATA_W'(a));
    write_reg(CFG_LENGTH, l);
    @(negedge clk);
  endtask

  // Command driver: present the next pending transaction, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      command <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) expected_results.push_back(stego_predict(command));
      if (!start || !busy) begin
        if (start && idle_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 18);
          start <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          command <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: byte %02h complete %0d depth %0d",
                     result.result_byte, result.complete, result.active_depth);
        end else begin
          want = expected_results.pop_front();
          if (result.result_byte !== want.result_byte || result.complete !== want.complete ||
              result.active_depth !== want.active_depth) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch: expected byte %02h complete %0d depth %0d, got byte %02h complete %0d depth %0d",
                       want.result_byte, want.complete, want.active_depth,
                       result.result_byte, result.complete, result.active_depth);
          end
        end
      end
      if ((start && !busy) || done || write_enable) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int base, phase, phase_end, n, k, op;
    logic [3:0] d;
    logic a;
    logic [12:0] l;
    logic [7:0] hdr_val;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the low image bytes; transfers and random reads never go past them.
    for (int i = 0; i < FILL_BYTES; i++) queue_cmd(OP_LOAD, i, $urandom_range(0, 255));
    wait_drained();

    // Reset settings: no depth yet, then zero length.
    queue_cmd(OP_EMBED, '0, 8'hFF);
    queue_cmd(OP_EXTRACT, '0, 8'h00);
    queue_cmd(OP_START, '0, 8'h00);
    queue_cmd(OP_EMBED, '0, 8'h5A);
    queue_cmd(OP_UNKNOWN_LAST, '1, 8'hFF);
    queue_cmd(OP_LOAD, '1, 8'h00);
    queue_cmd(OP_READ, '1, 8'h00);

    // Depth 3 straddles bytes; alpha skip and capacity cut the fourth byte.
    set_config(4'd3, 1'b1, 13'd12);
    queue_cmd(OP_START, '0, 8'h00);
    queue_cmd(OP_EMBED, '0, 8'hFF);
    queue_cmd(OP_EMBED, '0, 8'h00);
    queue_cmd(OP_EMBED, '0, 8'hA5);
    queue_cmd(OP_EMBED, '0, 8'h3C);
    queue_cmd(OP_READ, 12'd1, 8'h00);
    queue_cmd(OP_START, '0, 8'h00);
    for (int i = 0; i < 4; i++) queue_cmd(OP_EXTRACT, '0, 8'h00);

    // Header detection: broken pattern, zero, all ones.
    set_config(4'd0, 1'b0, 13'd4096);
    queue_cmd(OP_LOAD, '0, 8'h05);
    queue_cmd(OP_START, '0, 8'h00);
    queue_cmd(OP_LOAD, '0, 8'h00);
    queue_cmd(OP_START, '0, 8'h00);
    queue_cmd(OP_LOAD, '0, 8'hFF);
    queue_cmd(OP_START, '0, 8'h00);
    queue_cmd(OP_EXTRACT, '0, 8'h00);

    base = queued_total;
    phase = 0;
    while (queued_total - base < RANDOM_ITEMS) begin
      if (queued_total - base > CALM_ITEMS) idle_on = 1'b0;
      case (phase)
        0: begin d = 4'd15; a = 1'b1; l = 13'd8191; end
        1: begin d = 4'd8; a = 1'b0; l = 13'd1; end
        2: begin d = 4'd0; a = 1'b1; l = 13'd4095; end
        3: begin d = 4'd1; a = 1'b0; l = 13'd4096; end
        default: begin
          d = 4'($urandom_range(0, 11));
          if (d > 8) d = 4'($urandom_range(9, 15));
          a = 1'($urandom_range(0, 1));
          k = $urandom_range(0, 9);
          if (k == 0) l = '0;
          else if (k == 1) l = 13'($urandom_range(0, 8191));
          else l = 13'($urandom_range(2, 48));
        end
      endcase
      set_config(d, a, l);
      phase_end = queued_total + 80;
      while (queued_total < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: header, start, embed run, start, extract run
          n = $urandom_range(1, 10);
          if (d == 0) begin
            if ($urandom_range(0, 3) != 0) hdr_val = 8'hFF >> $urandom_range(0, 7);
            else hdr_val = 8'($urandom_range(0, 255));
            queue_cmd(OP_LOAD, '0, hdr_val);
          end
          queue_cmd(OP_START, $urandom_range(0, 4095), $urandom_range(0, 255));
          for (int i = 0; i < n; i++)
            queue_cmd(OP_EMBED, $urandom_range(0, 4095), $urandom_range(0, 255));
          if ($urandom_range(0, 1) == 0)
            queue_cmd(OP_READ, $urandom_range(0, 63), $urandom_range(0, 255));
          queue_cmd(OP_START, $urandom_range(0, 4095), $urandom_range(0, 255));
          n = n + $urandom_range(0, 1);
          for (int i = 0; i < n; i++)
            queue_cmd(OP_EXTRACT, $urandom_range(0, 4095), $urandom_range(0, 255));
        end else begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) begin
            // restart the cursor before it can leave the filled bytes
            if (reach + XFER_SPAN > FILL_BYTES)
              queue_cmd(OP_START, $urandom_range(0, 4095), $urandom_range(0, 255));
            op = $urandom_range(0, 7);
            if (op == OP_READ)
              queue_cmd(op, $urandom_range(0, FILL_BYTES - 1), $urandom_range(0, 255));
            else
              queue_cmd(op, $urandom_range(0, 4095), $urandom_range(0, 255));
          end
        end
      end
      phase++;
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
